FILE: hdl/tcpr_pkg.sv
// ----------------------------------------------------------------------------
// tcpr_pkg: shared constants for the two-flow TCP reassembly block
// Result codes, header byte positions and default settings.
// ----------------------------------------------------------------------------
package tcpr_pkg;

    localparam int unsigned BUF_DEPTH_DEFAULT = 65536;
    localparam logic [15:0] MIN_LEN_RESET     = 16'd60;
    localparam logic [7:0]  PROTO_TCP         = 8'd6;

    // header byte positions within the Ethernet frame
    localparam logic [15:0] POS_PROTO     = 16'd23;
    localparam logic [15:0] POS_ADDR_LO   = 16'd26;
    localparam logic [15:0] POS_ADDR_HI   = 16'd33;
    localparam logic [15:0] POS_TCP_LO    = 16'd34;
    localparam logic [15:0] POS_TCP_HI    = 16'd41;
    localparam logic [15:0] POS_DOFF      = 16'd46;
    localparam logic [6:0]  TCP_HDR_BASE  = 7'd34;
    localparam logic [3:0]  DOFF_MIN      = 4'd5;

    // result kinds
    localparam logic KIND_SUMMARY = 1'b0;
    localparam logic KIND_READ    = 1'b1;

    // request function codes
    localparam logic FUNC_FRAME = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    // frame classes
    localparam logic [2:0] CLS_IGNORED  = 3'd0;
    localparam logic [2:0] CLS_SET_REQ  = 3'd1;
    localparam logic [2:0] CLS_SET_RSP  = 3'd2;
    localparam logic [2:0] CLS_REQ_DATA = 3'd3;
    localparam logic [2:0] CLS_RSP_DATA = 3'd4;
    localparam logic [2:0] CLS_BOTH     = 3'd5;
    localparam logic [2:0] CLS_NO_MATCH = 3'd6;

endpackage

FILE: hdl/tcp_two_flow_reassembly.sv
// ----------------------------------------------------------------------------
// tcp_two_flow_reassembly: two-flow TCP stream reassembly
// Parses frame bytes, learns a request and a response flow, stores matching
// payload bytes into two stream buffers and reports one summary per frame.
// ----------------------------------------------------------------------------
//  channel | ports                         | transfer carries
//  --------+-------------------------------+---------------------------------
//  input   | s_valid / s_ready             | one frame byte or one read request
//  result  | m_valid / m_ready             | frame summary or buffer read byte
//  config  | cfg_we / cfg_wdata            | min_data_frame_len, no handshake
//
//  One input transfer per cycle while s_ready is high. A result appears the
//  cycle after the transfer that causes it; read data comes from the buffer's
//  registered read port, loaded on that same transfer.
//  Reset (aresetn low, synchronous) clears flows, counters and parser state;
//  buffer contents stay undefined until written, no clearing pass.
//  s_ready drops only while a result waits and m_ready is low.
// ----------------------------------------------------------------------------
module tcp_two_flow_reassembly
    import tcpr_pkg::*;
#(
    parameter int unsigned BUF_DEPTH = BUF_DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_func,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    input  logic [15:0] s_frame_len,
    input  logic        s_read_dir,
    input  logic [15:0] s_read_addr,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [2:0]  m_frame_class,
    output logic [15:0] m_payload_len,
    output logic [16:0] m_request_len,
    output logic [16:0] m_response_len,
    output logic [31:0] m_request_packets,
    output logic [31:0] m_response_packets,
    output logic [31:0] m_frame_count,
    output logic        m_overflow,
    output logic [7:0]  m_read_data
);

    localparam int unsigned AW = $clog2(BUF_DEPTH);
    localparam int unsigned LW = AW + 1;
    localparam logic [32:0] DEPTH33 = 33'(BUF_DEPTH);

    // configuration
    logic [15:0] min_len_reg;

    // flow table
    logic [1:0]  fv_reg;
    logic [63:0] f_addrs_reg [2];
    logic [31:0] f_ports_reg [2];
    logic [7:0]  f_proto_reg [2];
    logic [31:0] f_start_reg [2];
    logic [LW-1:0] f_len_reg [2];
    logic [31:0] cnt_frames_reg, cnt_req_reg, cnt_rsp_reg;

    // parser
    logic [15:0] pos_reg;
    logic [63:0] h_addrs_reg;
    logic [31:0] h_ports_reg, h_seq_reg;
    logic [7:0]  h_proto_reg;
    logic [3:0]  h_doff_reg;
    logic        ovf_reg;

    // result register
    logic        m_valid_reg, m_kind_reg, m_ovf_reg;
    logic [2:0]  m_class_reg;
    logic [15:0] m_plen_reg;
    logic [LW-1:0] m_rlen_reg [2];
    logic [31:0] m_creq_reg, m_crsp_reg, m_cfrm_reg;
    logic        rd_dir_reg, rd_in_reg;

    logic acc, frame_acc, read_acc, last_acc;
    assign s_ready   = !m_valid_reg || m_ready;
    assign acc       = s_valid && s_ready;
    assign frame_acc = acc && (s_func == FUNC_FRAME);
    assign read_acc  = acc && (s_func == FUNC_READ);
    assign last_acc  = frame_acc && s_last_byte;

    // header decode
    logic [6:0]  hdr_end;
    logic        hdr_ok;
    logic [1:0]  match;
    logic [31:0] offset [2];
    logic [31:0] wpos [2];
    logic [1:0]  inbuf, wr_en;
    logic        store_ok, wr_cond, ovf_now;
    logic [15:0] plen;

    assign hdr_end  = TCP_HDR_BASE + {1'b0, h_doff_reg, 2'b00};
    assign hdr_ok   = (h_proto_reg == PROTO_TCP) && (h_doff_reg >= DOFF_MIN);
    assign store_ok = s_frame_len > min_len_reg;
    assign wr_cond  = (pos_reg > POS_DOFF) && hdr_ok && (pos_reg >= 16'(hdr_end))
                   && (pos_reg < s_frame_len) && (fv_reg == 2'b11) && store_ok;
    assign plen     = s_frame_len - 16'(hdr_end);

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            match[k]  = fv_reg[k] && (f_addrs_reg[k] == h_addrs_reg)
                     && (f_ports_reg[k] == h_ports_reg) && (f_proto_reg[k] == h_proto_reg);
            offset[k] = h_seq_reg - f_start_reg[k] - 32'd1;
            wpos[k]   = offset[k] + 32'(pos_reg) - 32'(hdr_end);
            inbuf[k]  = wpos[k] < 32'(BUF_DEPTH);
            wr_en[k]  = frame_acc && wr_cond && match[k] && inbuf[k];
        end
    end
    // flag a payload byte that lands outside the buffer
    assign ovf_now = frame_acc && wr_cond && ((match[0] && !inbuf[0]) || (match[1] && !inbuf[1]));

    // two buffers so both flows can store the same byte in the same cycle
    logic [7:0] rdata [2];
    for (genvar g = 0; g < 2; g++) begin : g_buf
        tcpr_buf #(.DEPTH(BUF_DEPTH)) u_buf (
            .aclk  (aclk),
            .we    (wr_en[g]),
            .waddr (wpos[g][AW-1:0]),
            .wdata (s_data_byte),
            .re    (read_acc && (s_read_dir == 1'(g))),
            .raddr (s_read_addr[AW-1:0]),
            .rdata (rdata[g])
        );
    end

    // end-of-frame decisions
    logic        frame_good, set_flow, set_k;
    logic [2:0]  cls;
    logic [32:0] newlen [2];
    logic [LW-1:0] satlen [2];

    assign frame_good = hdr_ok && ((17'(pos_reg) + 17'd1) >= 17'(hdr_end))
                     && (s_frame_len >= 16'(hdr_end));
    assign set_flow   = fv_reg != 2'b11;
    assign set_k      = fv_reg[0];

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            newlen[k] = {1'b0, offset[k]} + 33'(plen);
            satlen[k] = (newlen[k] > DEPTH33) ? LW'(BUF_DEPTH) : newlen[k][LW-1:0];
        end
        if (!frame_good)        cls = CLS_IGNORED;
        else if (set_flow)      cls = set_k ? CLS_SET_RSP : CLS_SET_REQ;
        else if (!store_ok)     cls = CLS_NO_MATCH;
        else if (&match)        cls = CLS_BOTH;
        else if (match[0])      cls = CLS_REQ_DATA;
        else if (match[1])      cls = CLS_RSP_DATA;
        else                    cls = CLS_NO_MATCH;
    end

    logic upd_data;
    assign upd_data = last_acc && frame_good && !set_flow && store_ok;

    // next values for the flow lengths and counters, shown in this summary
    logic [LW-1:0] len_next [2];
    logic [31:0]   cnt_frames_next, cnt_req_next, cnt_rsp_next;
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            len_next[k] = (upd_data && match[k]) ? satlen[k] : f_len_reg[k];
        end
        cnt_frames_next = cnt_frames_reg + (last_acc ? 32'd1 : 32'd0);
        cnt_req_next    = cnt_req_reg + ((upd_data && match[0]) ? 32'd1 : 32'd0);
        cnt_rsp_next    = cnt_rsp_reg + ((upd_data && match[1]) ? 32'd1 : 32'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_len_reg    <= MIN_LEN_RESET;
            fv_reg         <= 2'b00;
            cnt_frames_reg <= '0;
            cnt_req_reg    <= '0;
            cnt_rsp_reg    <= '0;
            pos_reg        <= '0;
            h_addrs_reg    <= '0;
            h_ports_reg    <= '0;
            h_seq_reg      <= '0;
            h_proto_reg    <= '0;
            h_doff_reg     <= '0;
            ovf_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
            for (int k = 0; k < 2; k++) begin
                f_addrs_reg[k] <= '0;
                f_ports_reg[k] <= '0;
                f_proto_reg[k] <= '0;
                f_start_reg[k] <= '0;
                f_len_reg[k]   <= '0;
            end
        end else begin
            if (cfg_we) begin
                min_len_reg <= cfg_wdata;
            end
            // load a new result, else hold the waiting one until it is taken
            m_valid_reg <= read_acc || last_acc || (m_valid_reg && !m_ready);

            if (frame_acc) begin
                cnt_frames_reg <= cnt_frames_next;
                cnt_req_reg    <= cnt_req_next;
                cnt_rsp_reg    <= cnt_rsp_next;
                f_len_reg[0]   <= len_next[0];
                f_len_reg[1]   <= len_next[1];
                if (last_acc) begin
                    // learn a flow from a good frame while one is still unset, then clear the parser
                    if (frame_good && set_flow) begin
                        f_addrs_reg[set_k] <= h_addrs_reg;
                        f_ports_reg[set_k] <= h_ports_reg;
                        f_proto_reg[set_k] <= h_proto_reg;
                        f_start_reg[set_k] <= h_seq_reg;
                        fv_reg[set_k]      <= 1'b1;
                    end
                    pos_reg     <= '0;
                    h_addrs_reg <= '0;
                    h_ports_reg <= '0;
                    h_seq_reg   <= '0;
                    h_proto_reg <= '0;
                    h_doff_reg  <= '0;
                    ovf_reg     <= 1'b0;
                end else begin
                    if (pos_reg != 16'hFFFF) begin
                        pos_reg <= pos_reg + 16'd1;
                    end
                    if (ovf_now) begin
                        ovf_reg <= 1'b1;
                    end
                    if (pos_reg == POS_PROTO) begin
                        h_proto_reg <= s_data_byte;
                    end
                    if (pos_reg >= POS_ADDR_LO && pos_reg <= POS_ADDR_HI) begin
                        h_addrs_reg <= {h_addrs_reg[55:0], s_data_byte};
                    end
                    if (pos_reg >= POS_TCP_LO && pos_reg <= POS_TCP_HI) begin
                        {h_ports_reg, h_seq_reg} <= {h_ports_reg[23:0], h_seq_reg, s_data_byte};
                    end
                    if (pos_reg == POS_DOFF) begin
                        h_doff_reg <= s_data_byte[7:4];
                    end
                end
            end
        end
    end

    // result payload, loaded on a transfer that produces a result
    always_ff @(posedge aclk) begin
        if (read_acc) begin
            m_kind_reg    <= KIND_READ;
            m_class_reg   <= CLS_IGNORED;
            m_plen_reg    <= '0;
            m_ovf_reg     <= 1'b0;
            m_rlen_reg[0] <= f_len_reg[0];
            m_rlen_reg[1] <= f_len_reg[1];
            m_creq_reg    <= cnt_req_reg;
            m_crsp_reg    <= cnt_rsp_reg;
            m_cfrm_reg    <= cnt_frames_reg;
            rd_dir_reg    <= s_read_dir;
            rd_in_reg     <= 17'(s_read_addr) < 17'(BUF_DEPTH);
        end else if (last_acc) begin
            m_kind_reg    <= KIND_SUMMARY;
            m_class_reg   <= cls;
            m_plen_reg    <= frame_good ? plen : 16'd0;
            m_ovf_reg     <= ovf_reg || ovf_now;
            m_rlen_reg[0] <= len_next[0];
            m_rlen_reg[1] <= len_next[1];
            m_creq_reg    <= cnt_req_next;
            m_crsp_reg    <= cnt_rsp_next;
            m_cfrm_reg    <= cnt_frames_next;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_kind             = m_kind_reg;
    assign m_frame_class      = m_class_reg;
    assign m_payload_len      = m_plen_reg;
    assign m_request_len      = 17'(m_rlen_reg[0]);
    assign m_response_len     = 17'(m_rlen_reg[1]);
    assign m_request_packets  = m_creq_reg;
    assign m_response_packets = m_crsp_reg;
    assign m_frame_count      = m_cfrm_reg;
    assign m_overflow         = m_ovf_reg;
    assign m_read_data        = (m_kind_reg == KIND_READ && rd_in_reg) ? rdata[rd_dir_reg] : 8'd0;

endmodule

FILE: hdl/tcpr_buf.sv
// ----------------------------------------------------------------------------
// tcpr_buf: stream byte buffer
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module tcpr_buf
    import tcpr_pkg::*;
#(
    parameter int unsigned DEPTH = BUF_DEPTH_DEFAULT
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [7:0]               wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [7:0]               rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: verif/tcp_two_flow_reassembly_tb.sv
// ----------------------------------------------------------------------------
// tcp_two_flow_reassembly_tb: self-checking bench for two-flow TCP reassembly
// Builds Ethernet/IPv4/TCP frames byte by byte, learns the two flows, pushes
// request and response data plus broken frames and buffer reads, and checks
// every summary and read result against an in-bench model of the parser.
// ----------------------------------------------------------------------------
module tcp_two_flow_reassembly_tb;
    import tcpr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  DEPTH       = BUF_DEPTH_DEFAULT;
    localparam int  CYCLE_LIMIT = 3000000;
    localparam int  PHASE_ITEMS = 105;

    typedef struct packed {
        logic        func;
        logic [7:0]  data;
        logic        last;
        logic [15:0] flen;
        logic        dir;
        logic [15:0] addr;
    } req_t;

    typedef struct packed {
        logic        kind;
        logic [2:0]  cls;
        logic [15:0] plen;
        logic [16:0] req_len;
        logic [16:0] rsp_len;
        logic [31:0] req_pkts;
        logic [31:0] rsp_pkts;
        logic [31:0] frames;
        logic        ovf;
        logic [7:0]  rdata;
    } summary_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_func = 1'b0;
    logic [7:0]  s_data_byte = '0;
    logic        s_last_byte = 1'b0;
    logic [15:0] s_frame_len = '0;
    logic        s_read_dir = 1'b0;
    logic [15:0] s_read_addr = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    summary_t    got;

    always #1 aclk = ~aclk;

    tcp_two_flow_reassembly u_top (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_func             (s_func),
        .s_data_byte        (s_data_byte),
        .s_last_byte        (s_last_byte),
        .s_frame_len        (s_frame_len),
        .s_read_dir         (s_read_dir),
        .s_read_addr        (s_read_addr),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_kind             (got.kind),
        .m_frame_class      (got.cls),
        .m_payload_len      (got.plen),
        .m_request_len      (got.req_len),
        .m_response_len     (got.rsp_len),
        .m_request_packets  (got.req_pkts),
        .m_response_packets (got.rsp_pkts),
        .m_frame_count      (got.frames),
        .m_overflow         (got.ovf),
        .m_read_data        (got.rdata)
    );

    // ------------------------------------------------------------------
    // Parser model state: learned flows, counters, header being captured
    // and the bytes written so far into the two stream buffers.
    // ------------------------------------------------------------------
    logic [15:0] min_len = MIN_LEN_RESET;
    logic [1:0]  flow_set = '0;
    logic [63:0] flow_addr [2];
    logic [31:0] flow_port [2];
    logic [7:0]  flow_prot [2];
    logic [31:0] flow_seq0 [2];
    logic [16:0] flow_bytes [2];
    logic [31:0] pkt_cnt [3];
    logic [15:0] byte_pos = '0;
    logic [63:0] hdr_addr = '0;
    logic [63:0] hdr_tcp = '0;
    logic [15:0] hdr_misc = '0;
    logic        frame_ovf = 1'b0;
    logic [7:0]  stream_mem [int];
    int          stored_keys [$];

    req_t        pending_reqs [$];
    summary_t    expected_results [$];
    int          errors = 0;
    int          cycles = 0;
    int          class_seen [8];
    int          reads_seen = 0;

    // request and response tuples, plus one that never matches
    logic [63:0] req_addrs;
    logic [31:0] req_ports;
    logic [31:0] req_isn;
    logic [31:0] rsp_isn;
    logic [63:0] other_addrs;

    initial begin
        for (int k = 0; k < 2; k++) begin
            flow_addr[k] = '0;
            flow_port[k] = '0;
            flow_prot[k] = '0;
            flow_seq0[k] = '0;
            flow_bytes[k] = '0;
        end
        for (int k = 0; k < 3; k++) pkt_cnt[k] = '0;
    end

    function automatic bit flow_hit(int k);
        return flow_set[k] && flow_addr[k] == hdr_addr && flow_port[k] == hdr_tcp[63:32] &&
               flow_prot[k] == hdr_misc[7:0];
    endfunction

    // Advance the parser model by one accepted transfer; queue its result.
    task automatic model_transfer(req_t it);
        summary_t    r;
        logic [15:0] p;
        int          hend;
        bit          hok;
        bit          hit [2];
        logic [31:0] a;
        logic [32:0] total;
        int          k;
        r = '0;
        r.req_len = flow_bytes[0];
        r.rsp_len = flow_bytes[1];
        if (it.func == FUNC_READ) begin
            r.kind = KIND_READ;
            r.req_pkts = pkt_cnt[1];
            r.rsp_pkts = pkt_cnt[2];
            r.frames = pkt_cnt[0];
            r.rdata = stream_mem[it.dir * DEPTH + it.addr];
            expected_results.push_back(r);
            return;
        end
        p = byte_pos;
        if (p == POS_PROTO) hdr_misc[7:0] = it.data;
        else if (p >= POS_ADDR_LO && p <= POS_ADDR_HI) hdr_addr = {hdr_addr[55:0], it.data};
        else if (p >= POS_TCP_LO && p <= POS_TCP_HI) hdr_tcp = {hdr_tcp[55:0], it.data};
        else if (p == POS_DOFF) hdr_misc[15:8] = {4'd0, it.data[7:4]};
        hend = TCP_HDR_BASE + 4 * hdr_misc[11:8];
        hok = hdr_misc[7:0] == PROTO_TCP && hdr_misc[11:8] >= DOFF_MIN;
        // store payload bytes of data frames into every matching flow
        if (p > POS_DOFF && hok && p >= hend && p < it.flen && flow_set == 2'b11 &&
            it.flen > min_len) begin
            for (k = 0; k < 2; k++) begin
                if (flow_hit(k)) begin
                    a = hdr_tcp[31:0] - flow_seq0[k] - 32'd1 + (p - hend);
                    if (a < DEPTH) begin
                        if (!stream_mem.exists(k * DEPTH + a)) stored_keys.push_back(k * DEPTH + a);
                        stream_mem[k * DEPTH + a] = it.data;
                    end else begin
                        frame_ovf = 1'b1;
                    end
                end
            end
        end
        if (byte_pos != 16'hFFFF) byte_pos++;
        if (!it.last) return;

        pkt_cnt[0]++;
        r.kind = KIND_SUMMARY;
        r.cls = CLS_IGNORED;
        if (hok && p + 1 >= hend && it.flen >= hend) begin
            r.plen = it.flen - hend;
            if (flow_set != 2'b11) begin
                k = flow_set[0] ? 1 : 0;
                flow_addr[k] = hdr_addr;
                flow_port[k] = hdr_tcp[63:32];
                flow_prot[k] = hdr_misc[7:0];
                flow_seq0[k] = hdr_tcp[31:0];
                flow_set[k] = 1'b1;
                r.cls = k ? CLS_SET_RSP : CLS_SET_REQ;
            end else if (it.flen > min_len) begin
                hit[0] = flow_hit(0);
                hit[1] = flow_hit(1);
                for (k = 0; k < 2; k++) begin
                    if (hit[k]) begin
                        total = {1'b0, hdr_tcp[31:0] - flow_seq0[k] - 32'd1} + r.plen;
                        flow_bytes[k] = total > DEPTH ? 17'(DEPTH) : total[16:0];
                        pkt_cnt[1 + k]++;
                    end
                end
                r.cls = (hit[0] && hit[1]) ? CLS_BOTH : hit[0] ? CLS_REQ_DATA :
                        hit[1] ? CLS_RSP_DATA : CLS_NO_MATCH;
            end else begin
                r.cls = CLS_NO_MATCH;
            end
        end
        r.req_len = flow_bytes[0];
        r.rsp_len = flow_bytes[1];
        r.req_pkts = pkt_cnt[1];
        r.rsp_pkts = pkt_cnt[2];
        r.frames = pkt_cnt[0];
        r.ovf = frame_ovf;
        expected_results.push_back(r);
        byte_pos = '0;
        hdr_addr = '0;
        hdr_tcp = '0;
        hdr_misc = '0;
        frame_ovf = 1'b0;
    endtask

    task automatic enqueue(req_t it);
        model_transfer(it);
        pending_reqs.push_back(it);
    endtask

    // Build one frame: Ethernet, fixed IPv4, TCP header of doff words, then
    // n payload bytes. Send only `sent` bytes when it is positive, and tag
    // the frame with the true length plus len_adj, or len_abs when given.
    task automatic send_frame(logic [63:0] addrs, logic [31:0] ports, logic [7:0] prot,
                              logic [3:0] doff, logic [31:0] seq, int n, int len_adj,
                              int len_abs = -1, int sent = 0);
        req_t        it;
        int          total;
        int          flen;
        logic [7:0]  b;
        logic [63:0] tcp_word;
        tcp_word = {ports, seq};
        total = (doff >= DOFF_MIN ? TCP_HDR_BASE + 4 * doff : 54) + n;
        flen = len_abs >= 0 ? len_abs : total + len_adj;
        if (flen < 0) flen = 0;
        if (flen > 65535) flen = 65535;
        if (sent <= 0) sent = total;
        for (int p = 0; p < sent; p++) begin
            b = 8'($urandom);
            if (p == POS_PROTO) b = prot;
            else if (p >= POS_ADDR_LO && p <= POS_ADDR_HI) b = addrs[63 - 8 * (p - 26) -: 8];
            else if (p >= POS_TCP_LO && p <= POS_TCP_HI) b = tcp_word[63 - 8 * (p - 34) -: 8];
            else if (p == POS_DOFF) b = {doff, b[3:0]};
            it = '0;
            it.func = FUNC_FRAME;
            it.data = b;
            it.last = (p == sent - 1);
            it.flen = 16'(flen);
            it.dir = 1'($urandom);
            it.addr = 16'($urandom);
            enqueue(it);
        end
    endtask

    // Read back the byte at a buffer key (direction times depth plus address).
    task automatic send_read(int key);
        req_t it;
        it = '0;
        it.func = FUNC_READ;
        it.data = 8'($urandom);
        it.last = 1'($urandom);
        it.flen = 16'($urandom);
        it.dir = key >= DEPTH;
        it.addr = 16'(key % DEPTH);
        enqueue(it);
    endtask

    task automatic read_random;
        if (stored_keys.size() > 0)
            send_read(stored_keys[$urandom_range(0, stored_keys.size() - 1)]);
    endtask

    task automatic random_frame;
        int          pick;
        int          k;
        logic [31:0] off;
        int          adj;
        logic [3:0]  doff;
        pick = $urandom_range(0, 99);
        k = pick < 50 ? 0 : 1;
        case ($urandom_range(0, 19))
            0:       off = $urandom;
            1, 2:    off = 32'd65510 + $urandom_range(0, 40);
            default: off = $urandom_range(0, 300);
        endcase
        adj = 0;
        if ($urandom_range(0, 9) == 0) adj = $urandom_range(1, 8);
        else if ($urandom_range(0, 9) == 0) adj = -$urandom_range(1, 8);
        doff = $urandom_range(0, 4) == 0 ? 4'($urandom_range(5, 15)) : DOFF_MIN;
        if (pick < 85) begin
            // well-formed data for one of the two flows
            send_frame(k ? {req_addrs[31:0], req_addrs[63:32]} : req_addrs,
                       k ? {req_ports[15:0], req_ports[31:16]} : req_ports, PROTO_TCP, doff,
                       (k ? rsp_isn : req_isn) + 32'd1 + off, $urandom_range(0, 24), adj);
        end else if (pick < 92) begin
            send_frame(other_addrs, 32'($urandom), PROTO_TCP, doff, 32'($urandom),
                       $urandom_range(0, 24), adj);
        end else begin
            // noise: wrong protocol, bad offset, truncated or random length
            send_frame(req_addrs, req_ports, $urandom_range(0, 1) ? 8'($urandom) : PROTO_TCP,
                       4'($urandom), req_isn + 32'd1 + off, $urandom_range(0, 24),
                       0, $urandom_range(0, 1) ? int'($urandom_range(0, 65535)) : -1,
                       $urandom_range(0, 2) == 0 ? $urandom_range(1, 50) : 0);
        end
    endtask

    // Hold until no request is pending, no result is outstanding and s_valid is low.
    task automatic wait_drained;
        do @(posedge aclk);
        while (pending_reqs.size() != 0 || expected_results.size() != 0 || s_valid);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_min_len(logic [15:0] v);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        min_len = v;
    endtask

    task automatic random_phase;
        int target;
        target = pending_reqs.size() + PHASE_ITEMS;
        while (pending_reqs.size() < target) begin
            if ($urandom_range(0, 4) == 0) read_random();
            else random_frame();
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------
    initial begin
        req_addrs = {32'($urandom), 32'($urandom)};
        req_ports = 32'($urandom);
        req_isn = $urandom;
        rsp_isn = $urandom;
        other_addrs = ~req_addrs;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // ignored frames before any flow is learned
        send_frame(req_addrs, req_ports, 8'd17, DOFF_MIN, req_isn, 4, 0);
        send_frame(req_addrs, req_ports, PROTO_TCP, 4'd4, req_isn, 4, 0);
        send_frame(req_addrs, req_ports, PROTO_TCP, DOFF_MIN, req_isn, 4, 0, -1, 20);
        send_frame(req_addrs, req_ports, PROTO_TCP, DOFF_MIN, req_isn, 4, 0, 0);
        send_frame(req_addrs, req_ports, PROTO_TCP, DOFF_MIN, req_isn, 4, 0, 53);
        // learn request then response flow
        send_frame(req_addrs, req_ports, PROTO_TCP, DOFF_MIN, req_isn, 10, 0);
        send_frame({req_addrs[31:0], req_addrs[63:32]}, {req_ports[15:0], req_ports[31:16]},
                   PROTO_TCP, DOFF_MIN, rsp_isn, 3, 0);
        // exactly at threshold: no store
        send_frame(req_addrs, req_ports, PROTO_TCP, DOFF_MIN, req_isn + 1, 6, 0);
        send_frame(req_addrs, req_ports, PROTO_TCP, DOFF_MIN, req_isn + 1, 20, 0);
        send_frame({req_addrs[31:0], req_addrs[63:32]}, {req_ports[15:0], req_ports[31:16]},
                   PROTO_TCP, 4'd15, rsp_isn + 1, 30, 0);
        send_frame(other_addrs, req_ports, PROTO_TCP, DOFF_MIN, req_isn + 1, 20, 0);
        // length field longer, then shorter than the bytes sent
        send_frame(req_addrs, req_ports, PROTO_TCP, DOFF_MIN, req_isn + 21, 10, 6);
        send_frame(req_addrs, req_ports, PROTO_TCP, DOFF_MIN, req_isn + 31, 12, -5);
        // straddle the buffer end, then a sequence behind the start
        send_frame(req_addrs, req_ports, PROTO_TCP, DOFF_MIN, req_isn + 65531, 20, 0);
        send_frame(req_addrs, req_ports, PROTO_TCP, DOFF_MIN, req_isn, 8, 0);
        send_read(0);
        send_read(65535);
        send_read(DEPTH);
        send_read(DEPTH + 29);

        random_phase();
        write_min_len(16'd0);
        random_phase();
        write_min_len(16'hFFFF);
        random_phase();
        write_min_len(MIN_LEN_RESET);
        random_phase();
        write_min_len(16'($urandom_range(54, 90)));
        random_phase();

        wait_drained();
        repeat (20) @(posedge aclk);
        $display("Covered %0d frame summaries and %0d buffer reads, %0d bytes stored.",
                 class_seen.sum(), reads_seen, stored_keys.size());
        $display("Classes ignored/set/req/rsp/none: %0d/%0d/%0d/%0d/%0d, %0d mismatches",
                 class_seen[0], class_seen[1] + class_seen[2], class_seen[3],
                 class_seen[4], class_seen[6], errors);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Input driver: hold each transfer until accepted, with random gaps.
    // ------------------------------------------------------------------
    int in_gap = 0;
    bit in_burst = 1'b0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!(s_valid && !s_ready)) begin
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                s_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                {s_func, s_data_byte, s_last_byte, s_frame_len, s_read_dir, s_read_addr}
                    <= pending_reqs.pop_front();
                s_valid <= 1'b1;
                // flip between bursty and gappy stretches now and then
                if ($urandom_range(0, 63) == 0) in_burst = ~in_burst;
                in_gap <= in_burst ? 0 : $urandom_range(0, 18);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: random backpressure, compare against oldest entry.
    // ------------------------------------------------------------------
    int out_stall = 0;
    bit out_burst = 1'b0;
    summary_t want;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (got.kind == KIND_READ) reads_seen++;
                else class_seen[got.cls]++;
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result %p", $realtime, got);
                end else begin
                    want = expected_results.pop_front();
                    if (want !== got) begin
                        errors++;
                        $display("%0t: mismatch expected %p actual %p", $realtime,
                                 want, got);
                    end
                end
                if ($urandom_range(0, 63) == 0) out_burst = ~out_burst;
                out_stall <= out_burst ? 0 : $urandom_range(0, 18);
                m_ready <= out_burst;
            end else if (out_stall > 0) begin
                out_stall <= out_stall - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Abort on a hang.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timed out with %0d results outstanding", expected_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

endmodule

FILE: sim.f
hdl/tcpr_pkg.sv
hdl/tcpr_buf.sv
hdl/tcp_two_flow_reassembly.sv
verif/tcp_two_flow_reassembly_tb.sv
